// ----- rtl/camera_yaw_pitch_basis_unit_defines.svh -----
// Assertion helpers for the camera basis unit.
`ifndef CAMERA_YAW_PITCH_BASIS_UNIT_DEFINES_SVH
`define CAMERA_YAW_PITCH_BASIS_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CYPB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cypb assertion failed");

// Next-cycle implication checked outside reset.
`define CYPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cypb assertion failed");

`endif

// ----- rtl/cypb_pkg.sv -----
`default_nettype none
package cypb_pkg;
  localparam int ANGLE_BITS      = 24;
  localparam int POS_FRAC_BITS   = 16;
  localparam int VEC_FRAC_BITS   = 14;
  localparam int TRIG_ITERATIONS = 16;
  localparam int TABLE_LEN       = 24;
  localparam int TAB_W           = $clog2(TABLE_LEN);
  localparam int PS              = 32 - ANGLE_BITS;

  localparam longint CORDIC_K      = 64'sd652032874;
  localparam longint PITCH_MAX_Q32 = 64'sd1005385296;
  localparam longint PITCH_MAX     = (PITCH_MAX_Q32 + ((64'sd1 <<< PS) >>> 1)) >>> PS;

  localparam logic signed [31:0] POS_X_RST = 32'(20 * (1 << POS_FRAC_BITS));
  localparam logic signed [31:0] POS_Y_RST = 32'(10 * (1 << POS_FRAC_BITS));
  localparam logic signed [31:0] POS_Z_RST = 32'(-60 * (1 << POS_FRAC_BITS));
  localparam logic [15:0]        SENS_RST  = 16'd13351;

  localparam logic REG_WALK_HEIGHT = 1'b0;
  localparam logic REG_SENSITIVITY = 1'b1;

  localparam logic [1:0] CMD_FWD   = 2'd0;
  localparam logic [1:0] CMD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_MOUSE = 2'd2;

  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };
endpackage
`default_nettype wire

// ----- rtl/camera_yaw_pitch_basis_unit.sv -----
`default_nettype none
// First-person camera: keeps position, yaw and pitch, and returns the position with the
// forward, right and up vectors for every request. One request is in flight at a time.
// A request takes these steps in order: the angles are updated for a mouse command, two
// 16-step passes of a shared CORDIC rotator (yaw, then pitch) each followed by unpacking
// the result, a multiply and an accumulate state per product on one shared 17x32
// multiplier (two for a pan, between the passes, six for the basis) and the output
// load. tready is high only while idle, so a request is taken only once the last is
// done. A finished result waits in the output register while the next request is
// taken; a result still unread when the next one is done holds the unit until it is.
`include "camera_yaw_pitch_basis_unit_defines.svh"
module camera_yaw_pitch_basis_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // command[1:0], pan_amount[33:2], mouse_dx[49:34], mouse_dy[65:50]
  input  wire logic [71:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x, pos_y, pos_z (32 each), then fwd_x/y/z, right_x/y/z, up_x/y/z (16 each)
  output logic [239:0]      m_tdata
);
  import cypb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOUSE = 7'b0000010,
    S_TRIG  = 7'b0000100,
    S_TEND  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    OP_PANX = 3'd0, OP_PANZ = 3'd1, OP_FX = 3'd2, OP_FZ = 3'd3,
    OP_UX = 3'd4, OP_UZ = 3'd5, OP_UYA = 3'd6, OP_UYB = 3'd7
  } op_t;

  localparam logic [TAB_W-1:0] LAST_IT = TAB_W'(TRIG_ITERATIONS - 1);
  localparam logic signed [23:0] PMAX = 24'(PITCH_MAX);

  state_t state;
  op_t    op;
  logic   phase;
  logic [TAB_W-1:0] cnt;
  logic signed [32:0] cx, cyv;
  logic signed [31:0] cz;
  logic [1:0] cq;

  logic [ANGLE_BITS-1:0]        yaw;
  logic signed [ANGLE_BITS-1:0] pitch;
  logic signed [31:0] posx, posy, posz, wh;
  logic [15:0] sens;

  logic [1:0] cmd;
  logic signed [31:0] amt;
  logic signed [15:0] mdx, mdy;

  logic signed [15:0] sy, cy, sp, cp, fx, fz, ux, uy, uz;
  logic signed [48:0] preg, acc;

  // ---------------- helpers
  function automatic logic signed [34:0] rnd14(input logic signed [48:0] p);
    logic signed [48:0] t;
    t = p + (49'sd1 <<< (VEC_FRAC_BITS - 1));
    return 35'(t >>> VEC_FRAC_BITS);
  endfunction

  function automatic logic signed [15:0] clampv(input logic signed [35:0] v);
    if (v > 36'sd16384) return 16'sd16384;
    else if (v < -36'sd16384) return -16'sd16384;
    else return 16'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    else if (v < -36'sd2147483648) return 32'sh80000000;
    else return 32'(v);
  endfunction

  // ---------------- CORDIC step and post-processing
  logic signed [32:0] dxs, dys;
  logic signed [31:0] atn;
  assign dxs = cyv >>> cnt;
  assign dys = cx >>> cnt;
  assign atn = $signed(ATAN_TURNS[cnt]);

  logic signed [33:0] xs, ys;
  logic signed [33:0] xs_r, ys_r;
  logic signed [15:0] s_res, c_res;
  always_comb begin
    case (cq)
      2'd0:    begin xs = 34'(cyv);  ys = 34'(cx);   end
      2'd1:    begin xs = 34'(cx);   ys = -34'(cyv); end
      2'd2:    begin xs = -34'(cyv); ys = -34'(cx);  end
      default: begin xs = -34'(cx);  ys = 34'(cyv);  end
    endcase
    xs_r = (xs + (34'sd1 <<< (29 - VEC_FRAC_BITS))) >>> (30 - VEC_FRAC_BITS);
    ys_r = (ys + (34'sd1 <<< (29 - VEC_FRAC_BITS))) >>> (30 - VEC_FRAC_BITS);
    s_res = clampv(36'(xs_r));
    c_res = clampv(36'(ys_r));
  end

  // ---------------- shared multiplier operands
  logic signed [16:0] ma;
  logic signed [31:0] mb;
  always_comb begin
    case (op)
      OP_PANX: begin ma = (cmd == CMD_FWD) ? 17'(sy) : 17'(cy); mb = amt; end
      OP_PANZ: begin ma = (cmd == CMD_FWD) ? 17'(cy) : -17'(sy); mb = amt; end
      OP_FX:   begin ma = 17'(sy);  mb = 32'(cp); end
      OP_FZ:   begin ma = 17'(cy);  mb = 32'(cp); end
      OP_UX:   begin ma = 17'(sy);  mb = 32'(sp); end
      OP_UZ:   begin ma = -17'(cy); mb = 32'(sp); end
      OP_UYA:  begin ma = 17'(sy);  mb = 32'(fx); end
      default: begin ma = 17'(cy);  mb = 32'(fz); end
    endcase
  end

  logic signed [34:0] r14;
  logic signed [34:0] r14_sum;
  assign r14     = rnd14(preg);
  assign r14_sum = rnd14(acc + preg);

  // mouse update
  logic signed [32:0] dyaw, dpitch;
  logic signed [34:0] pnew;
  assign dyaw   = mdx * $signed({1'b0, sens});
  assign dpitch = mdy * $signed({1'b0, sens});
  assign pnew   = 35'(pitch) - 35'(dpitch);

  logic [31:0] yaw_turn, pitch_turn;
  assign yaw_turn   = {yaw, {PS{1'b0}}};
  assign pitch_turn = {pitch, {PS{1'b0}}};

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= OP_PANX;
      phase    <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      yaw      <= '0;
      pitch    <= '0;
      posx     <= POS_X_RST;
      posy     <= POS_Y_RST;
      posz     <= POS_Z_RST;
      wh       <= '0;
      sens     <= SENS_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WALK_HEIGHT: wh   <= $signed(cfg_data);
          REG_SENSITIVITY: sens <= cfg_data[15:0];
          default: ;
        endcase
      end
      // S_DONE reloads the output itself
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tdata[1:0];
            amt   <= $signed(s_tdata[33:2]);
            mdx   <= $signed(s_tdata[49:34]);
            mdy   <= $signed(s_tdata[65:50]);
            state <= S_MOUSE;
          end
        end
        S_MOUSE: begin
          logic [31:0] ang;
          ang = yaw_turn;
          if (cmd == CMD_MOUSE) begin
            yaw <= yaw + dyaw[ANGLE_BITS-1:0];
            ang = {yaw + dyaw[ANGLE_BITS-1:0], {PS{1'b0}}};
            if (pnew > 35'(PMAX)) pitch <= PMAX;
            else if (pnew < -35'(PMAX)) pitch <= -PMAX;
            else pitch <= pnew[ANGLE_BITS-1:0];
          end
          cx    <= 33'(CORDIC_K);
          cyv   <= '0;
          cz    <= $signed({2'b00, ang[29:0]});
          cq    <= ang[31:30];
          cnt   <= '0;
          phase <= 1'b0;
          state <= S_TRIG;
        end
        S_TRIG: begin
          if (!cz[31]) begin
            cx  <= cx - dxs;
            cyv <= cyv + dys;
            cz  <= cz - atn;
          end else begin
            cx  <= cx + dxs;
            cyv <= cyv - dys;
            cz  <= cz + atn;
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IT) state <= S_TEND;
        end
        S_TEND: begin
          if (!phase) begin
            sy <= s_res;
            cy <= c_res;
            if (cmd == CMD_FWD || cmd == CMD_RIGHT) begin
              op    <= OP_PANX;
              state <= S_MUL;
            end else begin
              cx    <= 33'(CORDIC_K);
              cyv   <= '0;
              cz    <= $signed({2'b00, pitch_turn[29:0]});
              cq    <= pitch_turn[31:30];
              cnt   <= '0;
              phase <= 1'b1;
              state <= S_TRIG;
            end
          end else begin
            sp    <= s_res;
            cp    <= c_res;
            op    <= OP_FX;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          preg  <= 49'(ma) * 49'(mb);
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_MUL;
          op    <= op_t'(op + 3'd1);
          case (op)
            OP_PANX: posx <= sat32(36'(posx) + 36'(r14));
            OP_PANZ: begin
              posz  <= sat32(36'(posz) + 36'(r14));
              posy  <= wh;
              cx    <= 33'(CORDIC_K);
              cyv   <= '0;
              cz    <= $signed({2'b00, pitch_turn[29:0]});
              cq    <= pitch_turn[31:30];
              cnt   <= '0;
              phase <= 1'b1;
              state <= S_TRIG;
            end
            OP_FX:  fx  <= r14[15:0];
            OP_FZ:  fz  <= r14[15:0];
            OP_UX:  ux  <= clampv(-36'(r14));
            OP_UZ:  uz  <= clampv(36'(r14));
            OP_UYA: acc <= preg;
            default: begin
              uy    <= clampv(36'(r14_sum));
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {uz, uy, ux, sy, 16'd0, -cy, fz, sp, fx,
                        posz, posy, posx};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CYPB_ASSERT_IMPL(a_state_onehot, 1'b1, $onehot(state))
  `CYPB_ASSERT_IMPL(a_pitch_range, 1'b1, (pitch <= PMAX) && (pitch >= -PMAX))
  `CYPB_ASSERT_IMPL(a_right_y_zero, m_tvalid, m_tdata[175:160] == 16'd0)
  `CYPB_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state == S_MOUSE)
endmodule
`default_nettype wire
